// ===== rtl/rsz_pkg.sv =====
`default_nettype none
package rsz_pkg;

	// defaults for the top level parameters
	localparam int MAX_TEXELS_DEF = 65536;
	localparam int FRAC_BITS_DEF  = 8;

	// fixed field widths
	localparam int NUM_CH     = 4;
	localparam int COORD_W    = 12;
	localparam int LAYER_W    = 8;
	localparam int TEXEL_W    = 32;
	localparam int SIZE_W     = 13;
	localparam int DEPTH_W    = 9;
	localparam int CH_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// width of the full linear texel address before the range check
	localparam int FULL_ADDR_W = 36;

	// output queue
	localparam int OQ_DEPTH = 32;
	localparam int OQ_PTR_W = 5;
	localparam int OQ_CNT_W = 6;

	// modes carried in tuser
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNELS      = 3'd0,
		REG_SRC_WIDTH     = 3'd1,
		REG_SRC_HEIGHT    = 3'd2,
		REG_SRC_DEPTH     = 3'd3,
		REG_TARGET_WIDTH  = 3'd4,
		REG_TARGET_HEIGHT = 3'd5
	} cfg_reg_t;

	// item sideband that travels alongside the position divider
	typedef struct packed {
		logic                 valid;
		logic                 mode;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [LAYER_W-1:0]   z;
		logic [TEXEL_W-1:0]   texel;
		logic                 err;
		logic                 wr_ok;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/rsz_ram.sv =====
`default_nettype none
module rsz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/rsz_posdiv.sv =====
`default_nettype none
module rsz_posdiv import rsz_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int QW = SIZE_W + FRAC_BITS,
	localparam int DW = COORD_W + SIZE_W + FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic [DW-1:0]     dividend,
	input  wire logic [SIZE_W-1:0] divisor,
	output logic      [QW-1:0]     quot
);

	logic [DW-1:0] rem_s [1:QW];
	logic [QW-1:0] q_s   [1:QW];

	// restoring division, one quotient bit per stage, msb first
	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int B = QW - 1 - i;
		logic [DW-1:0] rem_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] sub;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_in = dividend;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign q_in   = q_s[i];
		end

		assign sub  = DW'(divisor) << B;
		assign take = rem_in >= sub;

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? rem_in - sub : rem_in;
			q_s[i+1]   <= {q_in[QW-2:0], take};
		end
	end

	// a unit target size maps everything to position zero
	assign quot = (divisor == '0) ? '0 : q_s[QW];

endmodule
`default_nettype wire

// ===== rtl/rsz_blend.sv =====
`default_nettype none
module rsz_blend import rsz_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic [TEXEL_W-1:0]   tex [4],
	input  wire logic [FRAC_BITS-1:0] fx,
	input  wire logic [FRAC_BITS-1:0] fy,
	input  wire logic [CH_W-1:0]      nch,
	input  wire logic                 err,
	output logic      [7:0]           pix [NUM_CH]
);

	localparam int WW = FRAC_BITS + 1;
	localparam int RW = 8 + FRAC_BITS;
	localparam int VW = 8 + 2 * FRAC_BITS + 1;
	localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

	logic [WW-1:0] wx0, wx1;
	logic [RW-1:0] r0_s7 [NUM_CH];
	logic [RW-1:0] r1_s7 [NUM_CH];
	logic [WW-1:0] fy_s7;
	logic          keep_s7 [NUM_CH];

	assign wx0 = ONE - WW'(fx);
	assign wx1 = WW'(fx);

	for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
		logic [7:0]    a, b, c, d;
		logic [VW-1:0] v;

		assign a = tex[0][8*k +: 8];
		assign b = tex[1][8*k +: 8];
		assign c = tex[2][8*k +: 8];
		assign d = tex[3][8*k +: 8];

		// horizontal blend of both rows
		always_ff @(posedge clk) begin
			r0_s7[k]   <= RW'(RW'(a) * RW'(wx0)) + RW'(RW'(b) * RW'(wx1));
			r1_s7[k]   <= RW'(RW'(c) * RW'(wx0)) + RW'(RW'(d) * RW'(wx1));
			keep_s7[k] <= !err && (CH_W'(k) < nch);
		end

		// vertical blend and truncation to a byte
		assign v = VW'(VW'(r0_s7[k]) * VW'(ONE - fy_s7)) + VW'(VW'(r1_s7[k]) * VW'(fy_s7));

		always_ff @(posedge clk) begin
			pix[k] <= keep_s7[k] ? v[2*FRAC_BITS +: 8] : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		fy_s7 <= WW'(fy);
	end

endmodule
`default_nettype wire

// ===== rtl/bilinear_image_resampler_top.sv =====
// Bilinear image resampler with an on-chip texel store.
// Input stream (s_*): tuser is the mode, 0 writes a source texel, 1 samples a
// target pixel. tdata carries coord_x, coord_y, layer and four texel bytes.
// A write produces no output; a sample produces exactly one output transfer
// on m_* carrying four channel bytes in tdata and the range error in tuser.
// Configuration registers are loaded through cfg_we/cfg_index/cfg_data; the
// user must load them only while the block is idle; it is not enforced.
// Throughput: one item per clock while the output queue has room. The path
// from input transfer to output transfer runs through the position divider,
// a one bit per stage pipeline of 13 + FRAC_BITS stages, followed by
// address arithmetic, the texel store read and two blend stages.
// The texel store is held as four identical copies so that all four
// neighbours are read in the same cycle; every write goes to all copies.
// Results land in a 32 entry output queue; an input sample is only taken
// while the queue has room for it, so a stalled receiver fills the queue and
// then holds off s_tready, while writes keep the same rule.
// Reset clears the configuration to its defaults and empties the pipeline
// and queue; texel store contents are undefined until written.
`default_nettype none
module bilinear_image_resampler_top import rsz_pkg::*; #(
	parameter int MAX_TEXELS = MAX_TEXELS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// coord_x[11:0], coord_y[23:12], layer[31:24], chan0..chan3[63:32]
	input  wire logic [63:0]           s_tdata,
	// mode
	input  wire logic [0:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out0[7:0], out1[15:8], out2[23:16], out3[31:24]
	output logic      [31:0]           m_tdata,
	// range_error
	output logic      [0:0]            m_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int QW = SIZE_W + FRAC_BITS;
	localparam int DW = COORD_W + SIZE_W + FRAC_BITS;
	localparam int AW = $clog2(MAX_TEXELS);
	localparam int PW = COORD_W + SIZE_W;
	localparam int ZW = LAYER_W + SIZE_W;
	localparam int RYW = ZW + 1;
	localparam int ROWW = RYW + SIZE_W;

	// configuration registers
	logic [CH_W-1:0]    ch_q;
	logic [SIZE_W-1:0]  sw_q, sh_q, tw_q, th_q;
	logic [DEPTH_W-1:0] sd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= CH_W'(4);
			sw_q <= SIZE_W'(1);
			sh_q <= SIZE_W'(1);
			sd_q <= DEPTH_W'(1);
			tw_q <= SIZE_W'(1);
			th_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNELS:      ch_q <= cfg_data[CH_W-1:0];
				REG_SRC_WIDTH:     sw_q <= cfg_data[SIZE_W-1:0];
				REG_SRC_HEIGHT:    sh_q <= cfg_data[SIZE_W-1:0];
				REG_SRC_DEPTH:     sd_q <= cfg_data[DEPTH_W-1:0];
				REG_TARGET_WIDTH:  tw_q <= cfg_data[SIZE_W-1:0];
				REG_TARGET_HEIGHT: th_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes, a zero size acts as one
	logic [SIZE_W-1:0]  sw_e, sh_e, tw_e, th_e;
	logic [DEPTH_W-1:0] sd_e;
	logic [CH_W-1:0]    nch;

	assign sw_e = (sw_q == '0) ? SIZE_W'(1) : sw_q;
	assign sh_e = (sh_q == '0) ? SIZE_W'(1) : sh_q;
	assign tw_e = (tw_q == '0) ? SIZE_W'(1) : tw_q;
	assign th_e = (th_q == '0) ? SIZE_W'(1) : th_q;
	assign sd_e = (sd_q == '0) ? DEPTH_W'(1) : sd_q;
	assign nch  = (ch_q == '0) ? CH_W'(1) :
	              (ch_q > CH_W'(NUM_CH)) ? CH_W'(NUM_CH) : ch_q;

	// input transfer and queue credit
	logic                s_acc;
	logic [OQ_CNT_W-1:0] pending_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic                pop;

	assign s_tready = pending_q < OQ_CNT_W'(OQ_DEPTH);
	assign s_acc    = s_tvalid && s_tready;

	// stage 1: input register
	logic               v_s1;
	logic               mode_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [LAYER_W-1:0] z_s1;
	logic [TEXEL_W-1:0] texel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= s_acc;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= s_tuser[0];
		x_s1     <= s_tdata[11:0];
		y_s1     <= s_tdata[23:12];
		z_s1     <= s_tdata[31:24];
		texel_s1 <= s_tdata[63:32];
	end

	// stage 2: dividend products and range checks
	side_t           side_s2;
	logic [PW-1:0]   prodx_s2, prody_s2;
	logic [SIZE_W-1:0] sw_m1, sh_m1, tw_m1, th_m1;

	assign sw_m1 = sw_e - SIZE_W'(1);
	assign sh_m1 = sh_e - SIZE_W'(1);
	assign tw_m1 = tw_e - SIZE_W'(1);
	assign th_m1 = th_e - SIZE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2.valid <= v_s1;
			side_s2.mode  <= mode_s1;
			side_s2.x     <= x_s1;
			side_s2.y     <= y_s1;
			side_s2.z     <= z_s1;
			side_s2.texel <= texel_s1;
			side_s2.err   <= (SIZE_W'(x_s1) >= tw_e) || (SIZE_W'(y_s1) >= th_e) ||
			                 (DEPTH_W'(z_s1) >= sd_e);
			side_s2.wr_ok <= (SIZE_W'(x_s1) < sw_e) && (SIZE_W'(y_s1) < sh_e) &&
			                 (DEPTH_W'(z_s1) < sd_e);
		end
	end

	always_ff @(posedge clk) begin
		prodx_s2 <= PW'(x_s1) * PW'(sw_m1);
		prody_s2 <= PW'(y_s1) * PW'(sh_m1);
	end

	// position dividers with the sideband delayed alongside
	logic [QW-1:0] px, py;
	side_t         side_d [QW];

	rsz_posdiv #(.FRAC_BITS(FRAC_BITS)) u_divx (
		.clk      (clk),
		.dividend (DW'(prodx_s2) << FRAC_BITS),
		.divisor  (tw_m1),
		.quot     (px)
	);

	rsz_posdiv #(.FRAC_BITS(FRAC_BITS)) u_divy (
		.clk      (clk),
		.dividend (DW'(prody_s2) << FRAC_BITS),
		.divisor  (th_m1),
		.quot     (py)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				side_d[i] <= '0;
			end
		end else begin
			side_d[0] <= side_s2;
			for (int i = 1; i < QW; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// stage 3: neighbour coordinates and layer base
	side_t                side_s3;
	logic [SIZE_W-1:0]    x0_s3, x1_s3, y0_s3, y1_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic [ZW-1:0]        zh_s3;
	side_t                sdo;
	logic [SIZE_W-1:0]    pxi, pyi;
	logic [FRAC_BITS-1:0] pxf, pyf;

	assign sdo = side_d[QW-1];
	assign pxi = px[QW-1:FRAC_BITS];
	assign pyi = py[QW-1:FRAC_BITS];
	assign pxf = px[FRAC_BITS-1:0];
	assign pyf = py[FRAC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= sdo;
		end
	end

	always_ff @(posedge clk) begin
		if (sdo.mode == MODE_SAMPLE) begin
			x0_s3 <= pxi;
			y0_s3 <= pyi;
			x1_s3 <= pxi + SIZE_W'(pxf != '0);
			y1_s3 <= pyi + SIZE_W'(pyf != '0);
			fx_s3 <= pxf;
			fy_s3 <= pyf;
		end else begin
			x0_s3 <= SIZE_W'(sdo.x);
			y0_s3 <= SIZE_W'(sdo.y);
			x1_s3 <= SIZE_W'(sdo.x);
			y1_s3 <= SIZE_W'(sdo.y);
			fx_s3 <= '0;
			fy_s3 <= '0;
		end
		zh_s3 <= ZW'(sdo.z) * ZW'(sh_e);
	end

	// stage 4: row bases
	side_t                side_s4;
	logic [ROWW-1:0]      row0_s4, row1_s4;
	logic [SIZE_W-1:0]    x0_s4, x1_s4;
	logic [FRAC_BITS-1:0] fx_s4, fy_s4;
	logic [RYW-1:0]       ry0, ry1;

	assign ry0 = RYW'(zh_s3) + RYW'(y0_s3);
	assign ry1 = RYW'(zh_s3) + RYW'(y1_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		row0_s4 <= ROWW'(ry0) * ROWW'(sw_e);
		row1_s4 <= ROWW'(ry1) * ROWW'(sw_e);
		x0_s4   <= x0_s3;
		x1_s4   <= x1_s3;
		fx_s4   <= fx_s3;
		fy_s4   <= fy_s3;
	end

	// stage 5: the four texel addresses and store write
	side_t                side_s5;
	logic [AW-1:0]        addr_s5 [4];
	logic                 inb_s5 [4];
	logic                 we_s5;
	logic [FRAC_BITS-1:0] fx_s5, fy_s5;
	logic [FULL_ADDR_W-1:0] fa [4];

	assign fa[0] = FULL_ADDR_W'(row0_s4) + FULL_ADDR_W'(x0_s4);
	assign fa[1] = FULL_ADDR_W'(row0_s4) + FULL_ADDR_W'(x1_s4);
	assign fa[2] = FULL_ADDR_W'(row1_s4) + FULL_ADDR_W'(x0_s4);
	assign fa[3] = FULL_ADDR_W'(row1_s4) + FULL_ADDR_W'(x1_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
			we_s5   <= 1'b0;
		end else begin
			side_s5 <= side_s4;
			we_s5   <= side_s4.valid && (side_s4.mode == MODE_WRITE) && side_s4.wr_ok &&
			           (fa[0] < FULL_ADDR_W'(MAX_TEXELS));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			addr_s5[k] <= fa[k][AW-1:0];
			inb_s5[k]  <= fa[k] < FULL_ADDR_W'(MAX_TEXELS);
		end
		fx_s5 <= fx_s4;
		fy_s5 <= fy_s4;
	end

	// texel store, one copy per neighbour, writes and reads issued in item order
	logic [TEXEL_W-1:0] rdata [4];

	for (genvar k = 0; k < 4; k++) begin : g_store
		rsz_ram #(.WIDTH(TEXEL_W), .DEPTH(MAX_TEXELS)) u_ram (
			.clk   (clk),
			.we    (we_s5),
			.waddr (addr_s5[0]),
			.wdata (side_s5.texel),
			.raddr (addr_s5[k]),
			.rdata (rdata[k])
		);
	end

	// stage 6: read data, addresses beyond the store read as zero
	logic                 v_s6, err_s6;
	logic                 inb_s6 [4];
	logic [FRAC_BITS-1:0] fx_s6, fy_s6;
	logic [TEXEL_W-1:0]   tex [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= side_s5.valid && (side_s5.mode == MODE_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		err_s6 <= side_s5.err;
		fx_s6  <= fx_s5;
		fy_s6  <= fy_s5;
		for (int k = 0; k < 4; k++) begin
			inb_s6[k] <= inb_s5[k];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_tex
		assign tex[k] = inb_s6[k] ? rdata[k] : '0;
	end

	// stages 7 and 8: blend
	logic [7:0] pix [NUM_CH];
	logic       v_s7, v_s8, err_s7, err_s8;

	rsz_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk (clk),
		.tex (tex),
		.fx  (fx_s6),
		.fy  (fy_s6),
		.nch (nch),
		.err (err_s6),
		.pix (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		err_s7 <= err_s6;
		err_s8 <= err_s7;
	end

	// output queue
	logic [32:0]         oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic                push;

	assign push     = v_s8;
	assign m_tvalid = oq_cnt_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = oq_mem_q[oq_rd_q][31:0];
	assign m_tuser  = oq_mem_q[oq_rd_q][32];

	always_ff @(posedge clk) begin
		if (push) begin
			oq_mem_q[oq_wr_q] <= {err_s8, pix[3], pix[2], pix[1], pix[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q   <= '0;
			oq_rd_q   <= '0;
			oq_cnt_q  <= '0;
			pending_q <= '0;
		end else begin
			if (push) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			oq_cnt_q  <= oq_cnt_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
			pending_q <= pending_q + OQ_CNT_W'(s_acc && (s_tuser[0] == MODE_SAMPLE))
			             - OQ_CNT_W'(pop);
		end
	end

	// checks
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("outstanding sample count beyond queue depth");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= pending_q)
		else $error("queue holds more results than samples outstanding");

	a_sample_credit: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser[0] == MODE_SAMPLE) |=> pending_q != '0)
		else $error("accepted sample not counted");

endmodule
`default_nettype wire
